// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the mean spectrum builder RTL.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MSMB_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("msmb assertion failed");
`define MSMB_NEVER(lbl, clk, rstn, cond) \
    `MSMB_ASSERT(lbl, clk, rstn, !(cond))
`else
`define MSMB_ASSERT(lbl, clk, rstn, prop)
`define MSMB_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// File: hw/rtl/msmb_pkg.sv
// Shared widths, codes and types of the mean spectrum builder.
// No dependencies; imported by msmb_div and the top level.
`default_nettype none
package msmb_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = 32;
    localparam int COUNT_W     = 16;
    localparam int POS_W       = 10;
    localparam int SCENE_W     = 16;
    localparam int THR_W       = 15;
    localparam int CHECK_W     = 4;
    localparam int STATUS_W    = 3;
    localparam int OPCODE_W    = 2;
    localparam int MODE_W      = 2;
    localparam int BAND_SEL_W  = 10;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 48;

    localparam logic [OPCODE_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_READ   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_ACCUM       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_HELD        = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_OUT_SCENE   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_BACKGROUND  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_MEAN        = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_NO_VALID    = 3'd5;
    localparam logic [STATUS_W-1:0] STAT_COUNT_FULL  = 3'd6;

    localparam logic [MODE_W-1:0] MODE_UNDECIDED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACCEPTED  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OUT_SCENE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_REFUSED   = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_SCENE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCENE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BG_THRESHOLD = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_BANDS  = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SAMPLE_W-1:0] mean;
        logic [COUNT_W-1:0]  valid;
        logic [COUNT_W-1:0]  skipped;
    } result_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [4:0] {
        ST_CLEAR    = 5'b00001,
        ST_IDLE     = 5'b00010,
        ST_FLUSH    = 5'b00100,
        ST_DIV_LOAD = 5'b01000,
        ST_DIV_RUN  = 5'b10000
    } state_t;

    function automatic logic [SAMPLE_W:0] sample_mag(input logic [SAMPLE_W-1:0] v);
        logic [SAMPLE_W:0] ext;
        ext = {v[SAMPLE_W-1], v};
        return v[SAMPLE_W-1] ? (~ext + 1'b1) : ext;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/masked_spectrum_mean_builder_top.sv
// Mean spectrum builder for one class: band sum memory, pixel tracking, mean read-out.
// Depends on msmb_pkg, msmb_div and assert_macros.svh.
//
// Usage
//   s_ channel: one beat per item. s_tuser carries the opcode (sample, read mean, clear),
//   s_tlast marks the last band of a pixel, s_tdata carries row, col, band value, band.
//   m_ channel: exactly one result beat per input beat, in order: status in m_tuser,
//   mean, valid and skipped pixel counts in m_tdata.
//   cfg port: single-cycle register writes, only while the block is idle.
// Throughput and flow
//   A sample result passes the holding stage, then the m_ register; samples stream at one
//   per cycle while m_ takes results. The beat that accepts a pixel also replays its held
//   leading samples into the sum memory, one per cycle, min(band position, MAX_CHECK) of
//   them. A read beat with a non-zero count waits for the 32-step bit-serial divider,
//   with input held meanwhile. A clear beat returns at once, then the sum memory is swept.
// Reset and clear
//   After reset and after every clear beat, the sum memory is zeroed one entry per
//   cycle with s_tready low; configuration writes are still taken.
// Stall
//   One finished result waits in a holding stage while another sits on m_; further
//   input is refused (s_tready low) until the m_ side takes a beat.
`default_nettype none
`include "assert_macros.svh"
module masked_spectrum_mean_builder_top
    import msmb_pkg::*;
#(
    parameter int BANDS     = 256,
    parameter int MAX_CHECK = 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [15:0] row, [31:16] col, [47:32] band_value, [57:48] read_band, [63:58] zero
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    // [1:0] opcode
    input  wire logic [OPCODE_W-1:0]    s_tuser,
    input  wire logic                   s_tlast,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [15:0] mean_value, [31:16] valid_pixels, [47:32] skipped_pixels
    output logic [M_TDATA_W-1:0]        m_tdata,
    // [2:0] status
    output logic [STATUS_W-1:0]         m_tuser
);

    localparam int ABITS = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int HBITS = (MAX_CHECK > 1) ? $clog2(MAX_CHECK) : 1;
    localparam int CNT_W = $clog2(MAX_CHECK + 1);

    // configuration
    logic [SCENE_W-1:0] scene_width_reg;
    logic [SCENE_W-1:0] scene_height_reg;
    logic [THR_W-1:0]   bg_threshold_reg;
    logic [CHECK_W-1:0] check_bands_reg;

    // control state
    state_t             state_reg, state_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [COUNT_W-1:0] valid_count_reg, valid_count_next;
    logic [COUNT_W-1:0] skipped_count_reg, skipped_count_next;
    logic [ABITS-1:0]   clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0]   flush_idx_reg, flush_idx_next;
    logic [CNT_W-1:0]   flush_cnt_reg, flush_cnt_next;
    logic               rmw_valid_reg, rmw_valid_next;
    logic               in_range_reg, in_range_next;
    logic               pend_valid_reg, pend_valid_next;
    logic               m_valid_reg, m_valid_next;

    // payload
    logic [ABITS-1:0]    rmw_addr_reg, rmw_addr_next;
    logic [SAMPLE_W-1:0] rmw_addend_reg, rmw_addend_next;
    result_t             pend_reg, pend_next;
    result_t             m_data_reg, m_data_next;
    logic [SAMPLE_W-1:0] held_reg [MAX_CHECK];

    // sum memory
    logic [SUM_W-1:0] sums_mem [BANDS];
    logic [SUM_W-1:0] mem_rdata_reg;
    logic [SUM_W-1:0] fwd_data_reg;
    logic             fwd_hit_reg;
    logic             mem_we;
    logic [ABITS-1:0] mem_waddr;
    logic [SUM_W-1:0] mem_wdata;
    logic [ABITS-1:0] mem_raddr;
    logic [SUM_W-1:0] rd_sum;

    // item fields and decisions
    logic [SAMPLE_W-1:0]   in_row, in_col, in_value;
    logic [BAND_SEL_W-1:0] in_band;
    logic [OPCODE_W-1:0]   in_op;
    logic                  accept;
    logic                  out_free;
    logic                  end_of_pixel;
    logic                  count_full;
    logic                  out_of_scene;
    logic [CHECK_W:0]      cb_ext;
    logic [CNT_W-1:0]      k_eff;
    logic                  hold_sample;
    logic                  held_bg;
    logic                  bg_pixel;
    logic [CNT_W-1:0]      flush_n;
    logic [COUNT_W-1:0]    skipped_inc;
    logic                  held_we;

    div_stat_t           div_stat;
    logic                div_start;
    logic [SUM_W-1:0]    div_dividend;
    logic [SAMPLE_W-1:0] div_quotient;

    assign in_row   = s_tdata[15:0];
    assign in_col   = s_tdata[31:16];
    assign in_value = s_tdata[47:32];
    assign in_band  = s_tdata[57:48];
    assign in_op    = s_tuser;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scene_width_reg  <= SCENE_W'(512);
            scene_height_reg <= SCENE_W'(512);
            bg_threshold_reg <= '0;
            check_bands_reg  <= CHECK_W'(5);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SCENE_WIDTH:  scene_width_reg  <= cfg_wdata;
                CFG_SCENE_HEIGHT: scene_height_reg <= cfg_wdata;
                CFG_BG_THRESHOLD: bg_threshold_reg <= cfg_wdata[THR_W-1:0];
                CFG_CHECK_BANDS:  check_bands_reg  <= cfg_wdata[CHECK_W-1:0];
            endcase
        end
    end

    // pixel decision terms
    assign end_of_pixel = s_tlast || (pos_reg >= POS_W'(BANDS - 1));
    assign count_full   = valid_count_reg == {COUNT_W{1'b1}};
    assign out_of_scene = in_row[SAMPLE_W-1] || in_col[SAMPLE_W-1] ||
                          (in_row >= scene_height_reg) || (in_col >= scene_width_reg);
    assign cb_ext       = {1'b0, check_bands_reg};
    assign k_eff        = (check_bands_reg == '0) ? CNT_W'(1) :
                          (cb_ext > (CHECK_W+1)'(MAX_CHECK)) ? CNT_W'(MAX_CHECK) :
                          CNT_W'(cb_ext);
    assign hold_sample  = !end_of_pixel && (pos_reg < (POS_W'(k_eff) - POS_W'(1)));
    assign flush_n      = (pos_reg >= POS_W'(MAX_CHECK)) ? CNT_W'(MAX_CHECK)
                                                         : CNT_W'(pos_reg);
    assign skipped_inc  = (skipped_count_reg == {COUNT_W{1'b1}}) ? skipped_count_reg
                                                                  : skipped_count_reg + 1'b1;

    always_comb begin
        held_bg = 1'b1;
        for (int i = 0; i < MAX_CHECK; i++) begin
            if ((POS_W'(i) < pos_reg) &&
                (sample_mag(held_reg[i]) > {2'b00, bg_threshold_reg})) begin
                held_bg = 1'b0;
            end
        end
    end

    assign bg_pixel = held_bg && (sample_mag(in_value) <= {2'b00, bg_threshold_reg});

    // handshake
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && (!pend_valid_reg || out_free);
    assign accept   = s_tvalid && s_tready;

    // memory port: clear sweep or the write half of a read-modify-write
    assign rd_sum    = fwd_hit_reg ? fwd_data_reg : mem_rdata_reg;
    assign mem_we    = (state_reg == ST_CLEAR) || rmw_valid_reg;
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : rmw_addr_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 :
                       rd_sum + {{(SUM_W-SAMPLE_W){rmw_addend_reg[SAMPLE_W-1]}}, rmw_addend_reg};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            sums_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= sums_mem[mem_raddr];
        fwd_hit_reg   <= mem_we && (mem_waddr == mem_raddr);
        fwd_data_reg  <= mem_wdata;
    end

    assign div_start    = state_reg == ST_DIV_LOAD;
    assign div_dividend = in_range_reg ? rd_sum : '0;

    msmb_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (valid_count_reg),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    always_comb begin
        logic [STATUS_W-1:0] st;

        st                 = STAT_HELD;
        state_next         = state_reg;
        pos_next           = pos_reg;
        mode_next          = mode_reg;
        valid_count_next   = valid_count_reg;
        skipped_count_next = skipped_count_reg;
        clr_addr_next      = clr_addr_reg;
        flush_idx_next     = flush_idx_reg;
        flush_cnt_next     = flush_cnt_reg;
        rmw_valid_next     = 1'b0;
        rmw_addr_next      = rmw_addr_reg;
        rmw_addend_next    = rmw_addend_reg;
        in_range_next      = in_range_reg;
        pend_valid_next    = pend_valid_reg;
        pend_next          = pend_reg;
        m_valid_next       = m_valid_reg;
        m_data_next        = m_data_reg;
        mem_raddr          = pos_reg[ABITS-1:0];
        held_we            = 1'b0;

        if (pend_valid_reg && out_free) begin
            m_valid_next    = 1'b1;
            m_data_next     = pend_reg;
            pend_valid_next = 1'b0;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ABITS'(BANDS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (in_op)
                        OP_SAMPLE: begin
                            priority if (mode_reg == MODE_UNDECIDED && pos_reg == '0 &&
                                         out_of_scene) begin
                                mode_next = MODE_OUT_SCENE;
                                if (!count_full) skipped_count_next = skipped_inc;
                                st = count_full ? STAT_COUNT_FULL : STAT_OUT_SCENE;
                            end else if (mode_reg == MODE_UNDECIDED) begin
                                priority if (hold_sample) begin
                                    held_we = 1'b1;
                                    st      = STAT_HELD;
                                end else if (bg_pixel) begin
                                    mode_next = MODE_REFUSED;
                                    if (!count_full) skipped_count_next = skipped_inc;
                                    st = count_full ? STAT_COUNT_FULL : STAT_BACKGROUND;
                                end else if (count_full) begin
                                    mode_next = MODE_REFUSED;
                                    st        = STAT_COUNT_FULL;
                                end else begin
                                    rmw_valid_next   = 1'b1;
                                    rmw_addr_next    = pos_reg[ABITS-1:0];
                                    rmw_addend_next  = in_value;
                                    valid_count_next = valid_count_reg + 1'b1;
                                    mode_next        = MODE_ACCEPTED;
                                    st               = STAT_ACCUM;
                                    if (flush_n != '0) begin
                                        state_next     = ST_FLUSH;
                                        flush_idx_next = '0;
                                        flush_cnt_next = flush_n;
                                    end
                                end
                            end else if (mode_reg == MODE_ACCEPTED) begin
                                rmw_valid_next  = 1'b1;
                                rmw_addr_next   = pos_reg[ABITS-1:0];
                                rmw_addend_next = in_value;
                                st              = STAT_ACCUM;
                            end else begin
                                st = count_full ? STAT_COUNT_FULL :
                                     (mode_reg == MODE_OUT_SCENE) ? STAT_OUT_SCENE
                                                                  : STAT_BACKGROUND;
                            end
                            if (end_of_pixel) begin
                                pos_next  = '0;
                                mode_next = MODE_UNDECIDED;
                            end else begin
                                pos_next = pos_reg + 1'b1;
                            end
                            pend_valid_next = 1'b1;
                            pend_next       = '{status: st, mean: '0,
                                                valid: valid_count_next,
                                                skipped: skipped_count_next};
                        end
                        OP_READ: begin
                            if (valid_count_reg == '0) begin
                                pend_valid_next = 1'b1;
                                pend_next       = '{status: STAT_NO_VALID, mean: '0,
                                                    valid: valid_count_reg,
                                                    skipped: skipped_count_reg};
                            end else begin
                                mem_raddr     = in_band[ABITS-1:0];
                                in_range_next = {1'b0, in_band} < (BAND_SEL_W+1)'(BANDS);
                                state_next    = ST_DIV_LOAD;
                            end
                        end
                        OP_CLEAR: begin
                            valid_count_next   = '0;
                            skipped_count_next = '0;
                            pos_next           = '0;
                            mode_next          = MODE_UNDECIDED;
                            clr_addr_next      = '0;
                            state_next         = ST_CLEAR;
                            pend_valid_next    = 1'b1;
                            pend_next          = '{status: STAT_ACCUM, mean: '0,
                                                   valid: '0, skipped: '0};
                        end
                        default: begin
                            pend_valid_next = 1'b1;
                            pend_next       = '{status: STAT_HELD, mean: '0,
                                                valid: valid_count_reg,
                                                skipped: skipped_count_reg};
                        end
                    endcase
                end
            end
            ST_FLUSH: begin
                // replay the held leading samples of the pixel just accepted
                mem_raddr       = ABITS'(flush_idx_reg);
                rmw_valid_next  = 1'b1;
                rmw_addr_next   = ABITS'(flush_idx_reg);
                rmw_addend_next = held_reg[flush_idx_reg[HBITS-1:0]];
                flush_idx_next  = flush_idx_reg + 1'b1;
                if (flush_idx_reg == flush_cnt_reg - 1'b1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV_LOAD: begin
                state_next = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                if (div_stat.done) begin
                    state_next      = ST_IDLE;
                    pend_valid_next = 1'b1;
                    pend_next       = '{status: STAT_MEAN, mean: div_quotient,
                                        valid: valid_count_reg,
                                        skipped: skipped_count_reg};
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_CLEAR;
            pos_reg           <= '0;
            mode_reg          <= MODE_UNDECIDED;
            valid_count_reg   <= '0;
            skipped_count_reg <= '0;
            clr_addr_reg      <= '0;
            flush_idx_reg     <= '0;
            flush_cnt_reg     <= '0;
            rmw_valid_reg     <= 1'b0;
            in_range_reg      <= 1'b0;
            pend_valid_reg    <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            pos_reg           <= pos_next;
            mode_reg          <= mode_next;
            valid_count_reg   <= valid_count_next;
            skipped_count_reg <= skipped_count_next;
            clr_addr_reg      <= clr_addr_next;
            flush_idx_reg     <= flush_idx_next;
            flush_cnt_reg     <= flush_cnt_next;
            rmw_valid_reg     <= rmw_valid_next;
            in_range_reg      <= in_range_next;
            pend_valid_reg    <= pend_valid_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rmw_addr_reg   <= rmw_addr_next;
        rmw_addend_reg <= rmw_addend_next;
        pend_reg       <= pend_next;
        m_data_reg     <= m_data_next;
        if (held_we) begin
            held_reg[pos_reg[HBITS-1:0]] <= in_value;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_data_reg.skipped, m_data_reg.valid, m_data_reg.mean};
    assign m_tuser  = m_data_reg.status;

    `MSMB_ASSERT(a_read_starts_div, aclk, aresetn, (accept && in_op == OP_READ && valid_count_reg != '0) |=> (state_reg == ST_DIV_LOAD))
    `MSMB_ASSERT(a_valid_count_steps, aclk, aresetn, (valid_count_reg != $past(valid_count_reg)) |-> ((valid_count_reg == $past(valid_count_reg) + 16'd1) || (valid_count_reg == '0)))
    `MSMB_ASSERT(a_flush_in_range, aclk, aresetn, (state_reg == ST_FLUSH) |-> (flush_idx_reg < flush_cnt_reg))
    `MSMB_NEVER(a_no_rmw_in_sweep, aclk, aresetn, (state_reg == ST_CLEAR) && rmw_valid_reg)

endmodule
`default_nettype wire

// File: hw/rtl/msmb_div.sv
// Radix-2 restoring divider: signed band sum by unsigned pixel count, one bit a cycle.
// Depends on msmb_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module msmb_div
    import msmb_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [SUM_W-1:0]   dividend,
    input  wire logic [COUNT_W-1:0] divisor,
    output div_stat_t               stat,
    output logic [SAMPLE_W-1:0]     quotient
);

    localparam int STEP_W = $clog2(SUM_W);

    logic               busy_reg;
    logic               done_reg;
    logic               neg_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [COUNT_W-1:0] rem_reg;
    logic [COUNT_W-1:0] dvsr_reg;
    logic [SUM_W-1:0]   quo_reg;

    logic [COUNT_W:0]   rem_shift;
    logic [COUNT_W:0]   rem_sub;
    logic               fits;

    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign fits      = rem_shift >= {1'b0, dvsr_reg};
    assign rem_sub   = rem_shift - {1'b0, dvsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg  <= dividend[SUM_W-1];
            quo_reg  <= dividend[SUM_W-1] ? SUM_W'(~dividend + 1'b1) : dividend;
            rem_reg  <= '0;
            dvsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? rem_sub[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
        end
    end

    // truncation toward zero: divide magnitudes, restore the sign
    assign quotient = neg_reg ? SAMPLE_W'(~quo_reg[SAMPLE_W-1:0] + 1'b1)
                              : quo_reg[SAMPLE_W-1:0];
    assign stat     = '{busy: busy_reg, done: done_reg};

    `MSMB_ASSERT(a_div_start_busy, aclk, aresetn, start |=> busy_reg)
    `MSMB_ASSERT(a_div_done_after_busy, aclk, aresetn, done_reg |-> $past(busy_reg))
    `MSMB_ASSERT(a_div_rem_below, aclk, aresetn, (busy_reg && dvsr_reg != '0) |-> (rem_reg < dvsr_reg))

endmodule
`default_nettype wire

// File: bench/mean_spectrum_checker.sv
// Checker for masked_spectrum_mean_builder_top: follows register writes and input beats,
// predicts the result beat of each one and compares it with the m_ channel.
// Depends on msmb_pkg only; instantiated beside the block by tb.
module mean_spectrum_checker
    import msmb_pkg::*;
#(
    parameter int BANDS     = 256,
    parameter int MAX_CHECK = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic [OPCODE_W-1:0]    s_tuser,
    input  logic                   s_tlast,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    input  logic [STATUS_W-1:0]    m_tuser,
    output int                     fails,
    output int                     pending
);

    localparam int COUNT_MAX = 65535;

    longint                     band_sum [BANDS];
    int                         n_valid;
    int                         n_skipped;
    int                         band_pos;
    logic [MODE_W-1:0]          mode;
    logic signed [SAMPLE_W-1:0] held [MAX_CHECK];
    int                         width_r;
    int                         height_r;
    int                         thresh_r;
    int                         check_r;
    result_t                    mean_results [$];
    int                         beat_no;

    function automatic int magnitude(input logic signed [SAMPLE_W-1:0] v);
        int x;
        x = v;
        return x < 0 ? -x : x;
    endfunction

    function automatic void clear_class();
        foreach (band_sum[i])
            band_sum[i] = 0;
        n_valid   = 0;
        n_skipped = 0;
        band_pos  = 0;
        mode      = MODE_UNDECIDED;
    endfunction

    function automatic result_t accumulate_beat(input logic [OPCODE_W-1:0]  op,
                                                input logic [S_TDATA_W-1:0] d,
                                                input logic                 last);
        result_t                    r;
        int                         row;
        int                         col;
        int                         pos;
        int                         k;
        int                         b;
        int                         i;
        logic signed [SAMPLE_W-1:0] v;
        bit                         ends;
        bit                         full;
        bit                         bg;
        longint                     s;
        r        = '0;
        r.status = STAT_HELD;
        row      = $signed(d[15:0]);
        col      = $signed(d[31:16]);
        v        = d[47:32];
        b        = d[57:48];
        if (op == OP_SAMPLE) begin
            ends = last || band_pos >= BANDS - 1;
            full = n_valid >= COUNT_MAX;
            pos  = band_pos;
            if (mode == MODE_UNDECIDED && pos == 0 &&
                (row < 0 || col < 0 || row >= height_r || col >= width_r)) begin
                mode = MODE_OUT_SCENE;
                if (!full && n_skipped < COUNT_MAX)
                    n_skipped++;
                r.status = full ? STAT_COUNT_FULL : STAT_OUT_SCENE;
            end else if (mode == MODE_UNDECIDED) begin
                k = check_r < 1 ? 1 : (check_r > MAX_CHECK ? MAX_CHECK : check_r);
                if (!ends && pos < k - 1) begin
                    held[pos] = v;
                end else begin
                    bg = magnitude(v) <= thresh_r;
                    for (i = 0; i < pos && i < MAX_CHECK; i++)
                        if (magnitude(held[i]) > thresh_r)
                            bg = 1'b0;
                    if (bg) begin
                        mode = MODE_REFUSED;
                        if (!full && n_skipped < COUNT_MAX)
                            n_skipped++;
                        r.status = full ? STAT_COUNT_FULL : STAT_BACKGROUND;
                    end else if (full) begin
                        mode     = MODE_REFUSED;
                        r.status = STAT_COUNT_FULL;
                    end else begin
                        for (i = 0; i < pos && i < MAX_CHECK; i++)
                            band_sum[i] += held[i];
                        band_sum[pos] += v;
                        n_valid++;
                        mode     = MODE_ACCEPTED;
                        r.status = STAT_ACCUM;
                    end
                end
            end else if (mode == MODE_ACCEPTED) begin
                band_sum[pos] += v;
                r.status = STAT_ACCUM;
            end else begin
                r.status = full ? STAT_COUNT_FULL :
                           (mode == MODE_OUT_SCENE ? STAT_OUT_SCENE : STAT_BACKGROUND);
            end
            if (ends) begin
                band_pos = 0;
                mode     = MODE_UNDECIDED;
            end else begin
                band_pos = pos + 1;
            end
        end else if (op == OP_READ) begin
            if (n_valid == 0) begin
                r.status = STAT_NO_VALID;
            end else begin
                s        = b < BANDS ? band_sum[b] : 0;
                s        = s / n_valid;
                r.mean   = s[15:0];
                r.status = STAT_MEAN;
            end
        end else if (op == OP_CLEAR) begin
            clear_class();
            r.status = STAT_ACCUM;
        end
        r.valid   = n_valid[15:0];
        r.skipped = n_skipped[15:0];
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        result_t got;
        result_t want;
        if (!aresetn) begin
            clear_class();
            width_r  = 512;
            height_r = 512;
            thresh_r = 0;
            check_r  = 5;
            mean_results.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SCENE_WIDTH:  width_r  = cfg_wdata;
                    CFG_SCENE_HEIGHT: height_r = cfg_wdata;
                    CFG_BG_THRESHOLD: thresh_r = cfg_wdata[THR_W-1:0];
                    CFG_CHECK_BANDS:  check_r  = cfg_wdata[CHECK_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.status  = m_tuser;
                got.mean    = m_tdata[15:0];
                got.valid   = m_tdata[31:16];
                got.skipped = m_tdata[47:32];
                beat_no++;
                if (mean_results.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("result beat %0d with nothing expected: status %0d mean %0d",
                                 beat_no, got.status, $signed(got.mean));
                end else begin
                    want = mean_results.pop_front();
                    if (got.status !== want.status || got.mean !== want.mean ||
                        got.valid !== want.valid || got.skipped !== want.skipped) begin
                        fails++;
                        if (fails <= 10)
                            $display({"result beat %0d (expected/actual): status %0d/%0d ",
                                      "mean %0d/%0d valid %0d/%0d skipped %0d/%0d"},
                                     beat_no, want.status, got.status,
                                     $signed(want.mean), $signed(got.mean),
                                     want.valid, got.valid, want.skipped, got.skipped);
                    end
                end
            end
            if (s_tvalid && s_tready)
                mean_results.push_back(accumulate_beat(s_tuser, s_tdata, s_tlast));
        end
        pending = mean_results.size();
    end

endmodule

// File: bench/tb.sv
// Top of the testbench for masked_spectrum_mean_builder_top: clock, reset, register
// settings, input beats with random gaps, random m_ back-pressure and the verdict.
// Depends on msmb_pkg, the block's RTL and mean_spectrum_checker.
module tb;
    import msmb_pkg::*;

    localparam int BANDS       = 256;
    localparam int MAX_CHECK   = 8;
    localparam int IDLE_LIMIT  = 4000;
    localparam int PHASE_BEATS = 206;
    localparam logic [OPCODE_W-1:0] OP_NOP = 2'd3;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [OPCODE_W-1:0]    s_tuser   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]    m_tuser;

    int fails;
    int pending;
    int sent;
    int idle_cycles;
    int rx_wait;
    bit calm;
    bit m_beat;
    int cur_w   = 512;
    int cur_h   = 512;
    int cur_thr = 0;
    int cur_k   = 5;

    masked_spectrum_mean_builder_top #(.BANDS(BANDS), .MAX_CHECK(MAX_CHECK)) dut (.*);

    mean_spectrum_checker #(.BANDS(BANDS), .MAX_CHECK(MAX_CHECK)) spectrum_check (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk)
        m_beat <= m_tvalid && m_tready;

    // stall drawn per result beat taken
    always @(negedge aclk) begin
        if (m_beat)
            rx_wait = calm ? 0 : $urandom_range(0, 16);
        if (rx_wait > 0) begin
            m_tready <= 1'b0;
            rx_wait--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_beat(input logic [OPCODE_W-1:0] op, input logic [15:0] row,
                             input logic [15:0] col, input logic [15:0] val,
                             input logic last, input logic [9:0] band);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= last;
        s_tdata  <= {6'b0, band, val, col, row};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sent++;
        gap = calm ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic send_read(input logic [9:0] band);
        send_beat(OP_READ, $urandom, $urandom, $urandom, $urandom, band);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
    endtask

    task automatic next_setting(input int w, input int h, input int thr, input int k);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SCENE_WIDTH;
        cfg_wdata <= w;
        @(negedge aclk);
        cfg_index <= CFG_SCENE_HEIGHT;
        cfg_wdata <= h;
        @(negedge aclk);
        cfg_index <= CFG_BG_THRESHOLD;
        cfg_wdata <= thr;
        @(negedge aclk);
        cfg_index <= CFG_CHECK_BANDS;
        cfg_wdata <= k;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cur_w   = w;
        cur_h   = h;
        cur_thr = thr;
        cur_k   = k;
    endtask

    task automatic send_pixel(input int nb, input bit in_frame, input bit quiet,
                              input bit marked);
        int          row;
        int          col;
        int          lim;
        int          m;
        int          b;
        logic [15:0] val;
        lim = cur_h > 32768 ? 32768 : cur_h;
        row = $urandom_range(0, lim - 1);
        lim = cur_w > 32768 ? 32768 : cur_w;
        col = $urandom_range(0, lim - 1);
        if (!in_frame) begin
            case ($urandom_range(0, 3))
                0: row = -int'($urandom_range(1, 32768));
                1: col = -int'($urandom_range(1, 32768));
                2: row = cur_h <= 32767 ? int'($urandom_range(cur_h, 32767)) : -1;
                default: col = cur_w <= 32767 ? int'($urandom_range(cur_w, 32767)) : -1;
            endcase
        end
        for (b = 0; b < nb; b++) begin
            if (quiet && b < MAX_CHECK) begin
                m   = $urandom_range(0, cur_thr);
                val = $urandom_range(0, 1) ? -m : m;
            end else begin
                case ($urandom_range(0, 15))
                    0:       val = 16'h8000;
                    1:       val = 16'h7fff;
                    default: val = $urandom;
                endcase
            end
            send_beat(OP_SAMPLE, row[15:0], col[15:0], val, marked && b == nb - 1, $urandom);
            if ($urandom_range(0, 24) == 0)
                send_read($urandom_range(0, 15));
        end
    endtask

    task automatic random_phase(input int beats);
        int stop;
        int pick;
        int nb;
        bit lengthy;
        stop = sent + beats;
        while (sent < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 7) begin
                send_read($urandom_range(0, 3) == 0 ? $urandom_range(0, 1023)
                                                    : $urandom_range(0, 15));
            end else if (pick < 9) begin
                send_beat(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else if (pick < 10) begin
                send_beat(OP_NOP, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else if (pick < 13) begin
                send_beat(OP_SAMPLE, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
                lengthy = $urandom_range(0, 149) == 0;
                nb      = lengthy ? $urandom_range(256, 262) : $urandom_range(1, 12);
                send_pixel(nb, $urandom_range(0, 4) != 0, $urandom_range(0, 3) == 0,
                           !lengthy || $urandom_range(0, 1));
            end
            if ($urandom_range(0, 15) == 0)
                calm = !calm;
        end
    endtask

    initial begin : stimulus
        logic [15:0] extreme_vals [7];
        int          setups [8][4];
        logic [15:0] val;
        int          i;
        extreme_vals = '{16'h8000, 16'h7fff, 16'h0001, 16'hffff, 16'h0000, 16'h1000, 16'hf000};
        setups = '{'{1, 1, 0, 1}, '{65535, 65535, 32767, 8}, '{100, 37, 300, 3},
                   '{640, 480, 4096, 0}, '{20, 20, 50, 15}, '{65535, 1, 1000, 2},
                   '{7, 65535, 32767, 4}, '{512, 512, 0, 5}};
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: 512 x 512 scene, threshold 0, five check bands
        send_read(10'd0);
        send_beat(OP_NOP, 16'hffff, 16'hffff, 16'hffff, 1'b1, 10'h3ff);
        send_beat(OP_SAMPLE, 16'hffff, 16'd0, 16'd100, 1'b1, 10'd0);
        send_beat(OP_SAMPLE, 16'd0, 16'h8000, 16'd100, 1'b1, 10'd0);
        send_beat(OP_SAMPLE, 16'd512, 16'd5, 16'd100, 1'b1, 10'd0);
        for (i = 0; i < 5; i++)
            send_beat(OP_SAMPLE, 16'd0, 16'd0, 16'd0, i == 4, 10'd0);
        for (i = 0; i < 7; i++)
            send_beat(OP_SAMPLE, 16'd511, 16'd511, extreme_vals[i], i == 6, 10'd0);
        // ends before the check bands are all in
        send_beat(OP_SAMPLE, 16'd3, 16'd4, 16'h0000, 1'b0, 10'd0);
        send_beat(OP_SAMPLE, 16'd3, 16'd4, 16'h1000, 1'b1, 10'd0);
        send_read(10'd0);
        send_read(10'd1);
        send_read(10'd6);
        send_read(10'd1023);
        // clear with a pixel half way
        send_beat(OP_SAMPLE, 16'd1, 16'd1, 16'h0100, 1'b0, 10'd0);
        send_read(10'd0);
        send_beat(OP_CLEAR, 16'd0, 16'd0, 16'd0, 1'b0, 10'd0);
        send_read(10'd0);

        for (i = 0; i < 8; i++) begin
            next_setting(setups[i][0], setups[i][1], setups[i][2], setups[i][3]);
            if (i == 7)
                send_pixel(257, 1'b1, 1'b0, 1'b0);
            random_phase(PHASE_BEATS);
        end

        // valid count up to saturation
        next_setting(65535, 65535, 100, 1);
        calm = 1'b1;
        send_beat(OP_CLEAR, 16'd0, 16'd0, 16'd0, 1'b0, 10'd0);
        for (i = 0; i < 65534; i++) begin
            val = $urandom_range(101, 32767);
            if ($urandom_range(0, 1))
                val = -val;
            send_beat(OP_SAMPLE, $urandom_range(0, 32767), $urandom_range(0, 32767), val,
                      1'b1, $urandom);
        end
        for (i = 0; i < 4; i++)
            send_beat(OP_SAMPLE, 16'd2, 16'd2, 16'h2000, i == 3, 10'd0);
        send_beat(OP_SAMPLE, 16'hfffb, 16'd2, 16'h2000, 1'b1, 10'd0);
        send_beat(OP_SAMPLE, 16'd2, 16'd2, 16'd50, 1'b1, 10'd0);
        send_beat(OP_SAMPLE, 16'd2, 16'd2, 16'h2000, 1'b0, 10'd0);
        send_beat(OP_SAMPLE, 16'd2, 16'd2, 16'h2000, 1'b1, 10'd0);
        next_setting(65535, 65535, 100, 3);
        for (i = 0; i < 3; i++)
            send_beat(OP_SAMPLE, 16'd9, 16'd9, 16'h3000, i == 2, 10'd0);
        send_read(10'd0);
        send_read(10'd1);
        send_read(10'd3);
        send_read(10'd300);

        // skipped count up to saturation
        send_beat(OP_CLEAR, 16'd0, 16'd0, 16'd0, 1'b0, 10'd0);
        for (i = 0; i < 65537; i++)
            send_beat(OP_SAMPLE, 16'hffff, $urandom, $urandom, 1'b1, $urandom);
        send_beat(OP_SAMPLE, 16'd1, 16'd1, 16'd20, 1'b1, 10'd0);
        send_read(10'd0);

        drain();
        repeat (64) @(posedge aclk);
        if (fails == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/msmb_pkg.sv
hw/rtl/msmb_div.sv
hw/rtl/masked_spectrum_mean_builder_top.sv
bench/mean_spectrum_checker.sv
bench/tb.sv
